FILE: src/gab_pkg.sv
// Shared types, codes and constants of the glyph alpha blitter.
`timescale 1ns / 1ps

package gab_pkg;

    localparam int ADDR_W     = 22;
    localparam int SCREEN_W_W = 10;
    localparam int LINE_STEP  = 8;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] FULL_ALPHA   = 8'hFF;

    localparam logic [15:0] ORIGIN_X_RST    = 16'd0;
    localparam logic [15:0] ORIGIN_Y_RST    = 16'd0;
    localparam logic [9:0]  SCREEN_W_RST    = 10'd400;
    localparam logic [9:0]  SCREEN_H_RST    = 10'd240;
    localparam logic [7:0]  FONT_HEIGHT_RST = 8'd16;
    localparam logic [7:0]  COLOR_RST       = 8'd255;

    typedef enum logic [1:0] {
        REQ_HEADER = 2'd0,
        REQ_BYTE   = 2'd1,
        REQ_START  = 2'd2
    } gab_req_t;

    typedef enum logic {
        KIND_REPORT = 1'b0,
        KIND_PIXEL  = 1'b1
    } gab_kind_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_SCREEN_W    = 3'd2,
        REG_SCREEN_H    = 3'd3,
        REG_FONT_HEIGHT = 3'd4,
        REG_COLOR_R     = 3'd5,
        REG_COLOR_G     = 3'd6,
        REG_COLOR_B     = 3'd7
    } gab_reg_t;

    typedef struct packed {
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [9:0]  screen_w;
        logic [9:0]  screen_h;
        logic [7:0]  font_height;
        logic [7:0]  color_r;
        logic [7:0]  color_g;
        logic [7:0]  color_b;
    } gab_cfg_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic       has_data;
        logic [7:0] glyph_w;
        logic [7:0] glyph_h;
        logic [7:0] x_off;
        logic [7:0] y_off;
        logic [7:0] advance;
        logic [7:0] coverage;
        logic [7:0] dest_b;
        logic [7:0] dest_g;
        logic [7:0] dest_r;
    } gab_in_t;

    // Item between placement and blend stages.
    typedef struct packed {
        gab_kind_t  kind;
        logic [9:0] row;
        logic [7:0] coverage;
        logic [7:0] dest_b;
        logic [7:0] dest_g;
        logic [7:0] dest_r;
        logic [7:0] glyph_advance;
        logic       glyph_drawn;
    } gab_stage_t;

    typedef struct packed {
        gab_kind_t         kind;
        logic [ADDR_W-1:0] pixel_addr;
        logic [7:0]        new_b;
        logic [7:0]        new_g;
        logic [7:0]        new_r;
        logic [7:0]        glyph_advance;
        logic              glyph_drawn;
    } gab_out_t;

    // (old*(255-v) + colour*v) >> 8
    function automatic logic [7:0] blend8(input logic [7:0] d, input logic [7:0] c,
                                          input logic [7:0] v);
        logic [15:0] s;
        s = 16'(d) * 16'(FULL_ALPHA - v) + 16'(c) * 16'(v);
        return s[15:8];
    endfunction

endpackage

FILE: src/gab_place.sv
// Pen, clip and coverage walk state; registers one placed item per cycle while the downstream slot is free.
`timescale 1ns / 1ps

module gab_place #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  gab_pkg::gab_in_t       in_item,
    input  gab_pkg::gab_cfg_t      cfg,
    input  logic                   down_ready,
    output logic                   fire,
    output logic                   st_valid,
    output logic [COORD_WIDTH-1:0] st_col,
    output gab_pkg::gab_stage_t    st_item
);

    localparam int CW = COORD_WIDTH;
    localparam int EW = COORD_WIDTH + 2;

    logic [CW-1:0] pen_dx_reg, pen_dx_next;
    logic [CW-1:0] pen_dy_reg, pen_dy_next;
    logic [CW-1:0] gcol_reg, gcol_next;
    logic [CW-1:0] grow_reg, grow_next;
    logic [7:0]    cur_w_reg, cur_w_next;
    logic [7:0]    cur_h_reg, cur_h_next;
    logic [7:0]    bcol_reg, bcol_next;
    logic [7:0]    brow_reg, brow_next;
    logic          draw_en_reg, draw_en_next;

    logic                st_valid_reg, st_valid_next;
    logic [CW-1:0]       st_col_reg, st_col_next;
    gab_pkg::gab_stage_t st_item_reg, st_item_next;

    logic          slot_free;
    logic [CW-1:0] x_w, y_w;
    logic [7:0]    adv;
    logic signed [EW-1:0] x_e, y_e, gw_e, gh_e, sw_e, sh_e;
    logic signed [EW-1:0] col_e, row_e, bc_e, br_e;
    logic          drawn;
    logic          byte_ok;
    logic [8:0]    row_inc;
    logic          emit;

    assign slot_free = !st_valid_reg || down_ready;
    assign fire      = in_valid && slot_free;

    always_comb begin
        x_w = cfg.origin_x[CW-1:0] + pen_dx_reg
            + {{(CW-8){in_item.x_off[7]}}, in_item.x_off};
        y_w = cfg.origin_y[CW-1:0] + pen_dy_reg
            + {{(CW-8){1'b0}}, cfg.font_height}
            - {{(CW-8){in_item.y_off[7]}}, in_item.y_off}
            - {{(CW-8){1'b0}}, in_item.glyph_h};
        x_e  = {{2{x_w[CW-1]}}, x_w};
        y_e  = {{2{y_w[CW-1]}}, y_w};
        gw_e = {{(EW-8){1'b0}}, in_item.glyph_w};
        gh_e = {{(EW-8){1'b0}}, in_item.glyph_h};
        sw_e = {{(EW-gab_pkg::SCREEN_W_W){1'b0}}, cfg.screen_w};
        sh_e = {{(EW-gab_pkg::SCREEN_W_W){1'b0}}, cfg.screen_h};
        drawn = in_item.has_data && !(x_w[CW-1] || (x_e + gw_e >= sw_e)
                || (y_e + gh_e < 0) || (y_e >= sh_e + gh_e));
        adv = in_item.has_data ? in_item.advance : 8'd0;

        bc_e    = {{(EW-8){1'b0}}, bcol_reg};
        br_e    = {{(EW-8){1'b0}}, brow_reg};
        col_e   = {{2{gcol_reg[CW-1]}}, gcol_reg} + bc_e;
        row_e   = {{2{grow_reg[CW-1]}}, grow_reg} + br_e;
        byte_ok = (cur_w_reg != 8'd0) && (cur_h_reg != 8'd0) && (bcol_reg < cur_w_reg);
        row_inc = {1'b0, brow_reg} + 9'd1;
    end

    always_comb begin
        pen_dx_next  = pen_dx_reg;
        pen_dy_next  = pen_dy_reg;
        gcol_next    = gcol_reg;
        grow_next    = grow_reg;
        cur_w_next   = cur_w_reg;
        cur_h_next   = cur_h_reg;
        bcol_next    = bcol_reg;
        brow_next    = brow_reg;
        draw_en_next = draw_en_reg;
        emit         = 1'b0;

        st_item_next               = st_item_reg;
        st_col_next                = st_col_reg;
        st_item_next.kind          = gab_pkg::KIND_REPORT;
        st_item_next.row           = 10'd0;
        st_item_next.coverage      = in_item.coverage;
        st_item_next.dest_b        = in_item.dest_b;
        st_item_next.dest_g        = in_item.dest_g;
        st_item_next.dest_r        = in_item.dest_r;
        st_item_next.glyph_advance = 8'd0;
        st_item_next.glyph_drawn   = 1'b0;

        case (gab_pkg::gab_req_t'(in_item.req_type))
            gab_pkg::REQ_START: begin
                pen_dx_next  = '0;
                pen_dy_next  = '0;
                draw_en_next = 1'b0;
                cur_w_next   = 8'd0;
                cur_h_next   = 8'd0;
                bcol_next    = 8'd0;
                brow_next    = 8'd0;
            end
            gab_pkg::REQ_HEADER: begin
                emit      = 1'b1;
                bcol_next = 8'd0;
                brow_next = 8'd0;
                if (in_item.has_data) begin
                    gcol_next  = x_w;
                    grow_next  = y_w;
                    cur_w_next = in_item.glyph_w;
                    cur_h_next = in_item.glyph_h;
                end else begin
                    cur_w_next = 8'd0;
                    cur_h_next = 8'd0;
                end
                draw_en_next = drawn;
                if (in_item.char_code == gab_pkg::NEWLINE_CODE) begin
                    pen_dx_next = '0;
                    pen_dy_next = pen_dy_reg - CW'(gab_pkg::LINE_STEP);
                end else begin
                    pen_dx_next = pen_dx_reg + {{(CW-8){1'b0}}, adv};
                end
                st_item_next.glyph_advance = adv;
                st_item_next.glyph_drawn   = drawn;
            end
            gab_pkg::REQ_BYTE: begin
                if (byte_ok) begin
                    // walk down the column, then step to the next one
                    if (row_inc >= {1'b0, cur_h_reg}) begin
                        brow_next = 8'd0;
                        bcol_next = bcol_reg + 8'd1;
                    end else begin
                        brow_next = row_inc[7:0];
                    end
                    emit = draw_en_reg && (in_item.coverage != 8'd0) && !row_e[EW-1]
                        && (row_e < sh_e) && !col_e[EW-1];
                end
                st_item_next.kind = gab_pkg::KIND_PIXEL;
                st_item_next.row  = row_e[9:0];
                st_col_next       = col_e[CW-1:0];
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        if (fire) begin
            st_valid_next = emit;
        end else if (slot_free) begin
            st_valid_next = 1'b0;
        end else begin
            st_valid_next = st_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_dx_reg   <= '0;
            pen_dy_reg   <= '0;
            gcol_reg     <= '0;
            grow_reg     <= '0;
            cur_w_reg    <= 8'd0;
            cur_h_reg    <= 8'd0;
            bcol_reg     <= 8'd0;
            brow_reg     <= 8'd0;
            draw_en_reg  <= 1'b0;
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            if (fire) begin
                pen_dx_reg  <= pen_dx_next;
                pen_dy_reg  <= pen_dy_next;
                gcol_reg    <= gcol_next;
                grow_reg    <= grow_next;
                cur_w_reg   <= cur_w_next;
                cur_h_reg   <= cur_h_next;
                bcol_reg    <= bcol_next;
                brow_reg    <= brow_next;
                draw_en_reg <= draw_en_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            st_item_reg <= st_item_next;
            st_col_reg  <= st_col_next;
        end
    end

    assign st_valid = st_valid_reg;
    assign st_col   = st_col_reg;
    assign st_item  = st_item_reg;

endmodule

FILE: src/gab_blend.sv
// Pixel address and per-channel alpha blend of one placed item.
`timescale 1ns / 1ps

module gab_blend #(
    parameter int COORD_WIDTH = 16
) (
    input  logic [COORD_WIDTH-1:0] col,
    input  gab_pkg::gab_stage_t    item,
    input  gab_pkg::gab_cfg_t      cfg,
    output gab_pkg::gab_out_t      result
);

    localparam int PW = COORD_WIDTH + gab_pkg::SCREEN_W_W;
    localparam int AW = gab_pkg::ADDR_W;

    logic [PW-1:0] prod;
    logic [AW-1:0] lin;

    always_comb begin
        prod = PW'(col) * PW'(cfg.screen_h);
        lin  = prod[AW-1:0] + AW'(item.row);

        result.kind          = item.kind;
        result.pixel_addr    = '0;
        result.new_b         = 8'd0;
        result.new_g         = 8'd0;
        result.new_r         = 8'd0;
        result.glyph_advance = item.glyph_advance;
        result.glyph_drawn   = item.glyph_drawn;
        if (item.kind == gab_pkg::KIND_PIXEL) begin
            // times three, one byte per channel
            result.pixel_addr    = lin + {lin[AW-2:0], 1'b0};
            result.new_b         = gab_pkg::blend8(item.dest_b, cfg.color_b, item.coverage);
            result.new_g         = gab_pkg::blend8(item.dest_g, cfg.color_g, item.coverage);
            result.new_r         = gab_pkg::blend8(item.dest_r, cfg.color_r, item.coverage);
            result.glyph_advance = 8'd0;
            result.glyph_drawn   = 1'b0;
        end
    end

endmodule

FILE: src/gab_skid.sv
// Output register with a skid entry so upstream ready is registered.
`timescale 1ns / 1ps

module gab_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  gab_pkg::gab_out_t in_data,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output gab_pkg::gab_out_t out_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    gab_pkg::gab_out_t main_reg, main_next;
    gab_pkg::gab_out_t skid_reg, skid_next;
    logic              in_fire;
    logic              out_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = main_valid_reg && out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_fire) begin
            // refill the output from the skid entry first
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = in_data;
                main_valid_next = in_fire;
            end
        end else if (in_fire) begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

FILE: src/glyph_alpha_blit_top.sv
// Top level of the glyph alpha blitter: ports, configuration and input register.
`timescale 1ns / 1ps

// Draws anti-aliased text into a column-major BGR framebuffer. Send a
// string-start item, then for each character a glyph header followed by
// its coverage bytes, column by column. Each header answers with an
// advance report; each visible nonzero coverage byte answers with one
// blended pixel write at byte address (column*screen_h+row)*3. The block
// takes one item per clock while the output is not stalled and delivers
// results in order, through the input register, the placement register and
// the output register; the pen and coverage-walk registers update as each
// item is accepted, which is what lets a new item in on every clock.
// Write configuration registers only while no items are in flight.
module glyph_alpha_blit_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: char_code, has_data, glyph_w, glyph_h, x_off, y_off, advance,
    //        coverage, dest_b, dest_g, dest_r, zero pad
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,
    // tuser: req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: pixel_addr, new_b, new_g, new_r, glyph_advance, glyph_drawn, zero pad
    output logic [55:0] m_axis_tdata,
    // tuser: out_kind
    output logic        m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    gab_pkg::gab_cfg_t cfg_reg;
    logic              in_valid_reg;
    gab_pkg::gab_in_t  in_reg;
    gab_pkg::gab_in_t  in_unpacked;

    logic                   place_fire;
    logic                   st_valid;
    logic [COORD_WIDTH-1:0] st_col;
    gab_pkg::gab_stage_t    st_item;
    gab_pkg::gab_out_t      blend_out;
    gab_pkg::gab_out_t      out_item;
    logic                   skid_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x    <= gab_pkg::ORIGIN_X_RST;
            cfg_reg.origin_y    <= gab_pkg::ORIGIN_Y_RST;
            cfg_reg.screen_w    <= gab_pkg::SCREEN_W_RST;
            cfg_reg.screen_h    <= gab_pkg::SCREEN_H_RST;
            cfg_reg.font_height <= gab_pkg::FONT_HEIGHT_RST;
            cfg_reg.color_r     <= gab_pkg::COLOR_RST;
            cfg_reg.color_g     <= gab_pkg::COLOR_RST;
            cfg_reg.color_b     <= gab_pkg::COLOR_RST;
        end else if (cfg_valid) begin
            case (gab_pkg::gab_reg_t'(cfg_index))
                gab_pkg::REG_ORIGIN_X:    cfg_reg.origin_x    <= cfg_data;
                gab_pkg::REG_ORIGIN_Y:    cfg_reg.origin_y    <= cfg_data;
                gab_pkg::REG_SCREEN_W:    cfg_reg.screen_w    <= cfg_data[9:0];
                gab_pkg::REG_SCREEN_H:    cfg_reg.screen_h    <= cfg_data[9:0];
                gab_pkg::REG_FONT_HEIGHT: cfg_reg.font_height <= cfg_data[7:0];
                gab_pkg::REG_COLOR_R:     cfg_reg.color_r     <= cfg_data[7:0];
                gab_pkg::REG_COLOR_G:     cfg_reg.color_g     <= cfg_data[7:0];
                gab_pkg::REG_COLOR_B:     cfg_reg.color_b     <= cfg_data[7:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        in_unpacked.req_type  = s_axis_tuser;
        in_unpacked.char_code = s_axis_tdata[7:0];
        in_unpacked.has_data  = s_axis_tdata[8];
        in_unpacked.glyph_w   = s_axis_tdata[16:9];
        in_unpacked.glyph_h   = s_axis_tdata[24:17];
        in_unpacked.x_off     = s_axis_tdata[32:25];
        in_unpacked.y_off     = s_axis_tdata[40:33];
        in_unpacked.advance   = s_axis_tdata[48:41];
        in_unpacked.coverage  = s_axis_tdata[56:49];
        in_unpacked.dest_b    = s_axis_tdata[64:57];
        in_unpacked.dest_g    = s_axis_tdata[72:65];
        in_unpacked.dest_r    = s_axis_tdata[80:73];
    end

    // Input register: take a new item whenever it is empty or the held one moves on.
    assign s_axis_tready = !in_valid_reg || place_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_reg <= in_unpacked;
        end
    end

    gab_place #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_place (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_item   (in_reg),
        .cfg       (cfg_reg),
        .down_ready(skid_ready),
        .fire      (place_fire),
        .st_valid  (st_valid),
        .st_col    (st_col),
        .st_item   (st_item)
    );

    gab_blend #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_blend (
        .col   (st_col),
        .item  (st_item),
        .cfg   (cfg_reg),
        .result(blend_out)
    );

    gab_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (st_valid),
        .in_data  (blend_out),
        .in_ready (skid_ready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (out_item)
    );

    assign m_axis_tuser = out_item.kind;
    assign m_axis_tdata = {1'b0, out_item.glyph_drawn, out_item.glyph_advance,
                           out_item.new_r, out_item.new_g, out_item.new_b,
                           out_item.pixel_addr};

endmodule
